[hdl/bba_pkg.sv]
// Shared types and constants of the bitmap block allocator.
package bba_pkg;

   // Disk geometry
   localparam int CYLINDERS           = 8;
   localparam int BLOCKS_PER_CYLINDER = 8;
   localparam int RECORDS_PER_TRACK   = 4;
   localparam int TOTAL_BLOCKS        = CYLINDERS * BLOCKS_PER_CYLINDER;
   localparam int MAX_GRANTS          = 64;

   // Field and index widths
   localparam int IDX_W = $clog2(TOTAL_BLOCKS);
   localparam int CNT_W = 7;
   localparam int CYL_W = 3;
   localparam int TRK_W = 1;
   localparam int REC_W = 2;
   localparam int STS_W = 2;

   // Operation codes
   localparam logic OP_ALLOCATE = 1'b0;
   localparam logic OP_RELEASE  = 1'b1;

   // Result status codes
   localparam logic [STS_W-1:0] STATUS_GRANTED  = 2'd0;
   localparam logic [STS_W-1:0] STATUS_REFUSED  = 2'd1;
   localparam logic [STS_W-1:0] STATUS_EMPTY    = 2'd2;
   localparam logic [STS_W-1:0] STATUS_RELEASED = 2'd3;

   // Controller to datapath commands
   typedef struct packed {
      logic load;         // capture the incoming transaction
      logic emit_single;  // issue the one-result answer (release, refusal, empty)
      logic start_scan;   // rewind the scan pointer and grant count
      logic scan;         // examine one bitmap entry
   } bba_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic single;       // latched request answers with a single result
      logic slot_free;    // result register can take a new transaction
      logic grant_ready;  // current scan entry is free and can be issued
      logic grant_last;   // a grant issued now completes the request
   } bba_sts_type;

endpackage

[hdl/bba_ctrl.sv]
// Sequencing state machine of the bitmap block allocator.
module bba_ctrl
   import bba_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  bba_sts_type sts,
   output bba_cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_DECIDE = 3'b010,
      ST_SCAN   = 3'b100
   } state_type;

   state_type state_ff, state_in;

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (sts.single) begin
               if (sts.slot_free) begin
                  cmd.emit_single = 1'b1;
                  state_in        = ST_IDLE;
               end
            end else begin
               cmd.start_scan = 1'b1;
               state_in       = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.grant_ready && sts.grant_last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[hdl/bba_datapath.sv]
// Bitmap, free count, scan pointer and result register of the allocator.
module bba_datapath
   import bba_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  bba_cmd_type      cmd,
   output bba_sts_type      sts,
   input  logic             req_op,
   input  logic [CNT_W-1:0] req_request_count,
   input  logic [CYL_W-1:0] req_release_cylinder,
   input  logic [TRK_W-1:0] req_release_track,
   input  logic [REC_W-1:0] req_release_record,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [STS_W-1:0] rsp_status,
   output logic [CYL_W-1:0] rsp_cylinder,
   output logic [TRK_W-1:0] rsp_track,
   output logic [REC_W-1:0] rsp_record,
   output logic             rsp_last,
   output logic [CNT_W-1:0] rsp_free_blocks
);

   // Latched request
   logic             op_ff;
   logic [CNT_W-1:0] count_ff;
   logic [CYL_W-1:0] rcyl_ff;
   logic [TRK_W-1:0] rtrk_ff;
   logic [REC_W-1:0] rrec_ff;

   // Allocation state
   logic [TOTAL_BLOCKS-1:0] used_map_ff, used_map_in;
   logic [CNT_W-1:0]        free_ff, free_in;
   logic [IDX_W-1:0]        scan_idx_ff, scan_idx_in;
   logic [CNT_W-1:0]        done_ff, done_in;

   // Result register
   logic             rsp_valid_ff, rsp_valid_in;
   logic [STS_W-1:0] status_ff, status_in;
   logic [CYL_W-1:0] cyl_ff, cyl_in;
   logic [TRK_W-1:0] trk_ff, trk_in;
   logic [REC_W-1:0] rec_ff, rec_in;
   logic             last_ff, last_in;
   logic [CNT_W-1:0] fblk_ff, fblk_in;

   logic             slot_free;
   logic             map_bit;
   logic [CNT_W-1:0] rel_blk;
   logic [IDX_W-1:0] rel_idx;
   logic             rel_in_range;
   logic             rel_hit;
   logic [STS_W-1:0] single_code;
   logic             single;
   logic [IDX_W-1:0] blk_in_cyl;
   logic             grant_ready;
   logic             grant_last;

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign map_bit   = used_map_ff[scan_idx_ff];

   // Release address decode and range check
   assign rel_blk = CNT_W'(rtrk_ff) * CNT_W'(RECORDS_PER_TRACK) + CNT_W'(rrec_ff);
   assign rel_in_range = (int'(rcyl_ff) < CYLINDERS) && (int'(rel_blk) < BLOCKS_PER_CYLINDER);
   assign rel_idx = IDX_W'(CNT_W'(rcyl_ff) * CNT_W'(BLOCKS_PER_CYLINDER) + rel_blk);
   assign rel_hit = rel_in_range && used_map_ff[rel_idx];

   // Single-result decision
   always_comb begin
      single      = 1'b1;
      single_code = STATUS_RELEASED;
      if (op_ff == OP_ALLOCATE) begin
         if (count_ff == '0) begin
            single_code = STATUS_EMPTY;
         end else if ((count_ff > free_ff) || (int'(count_ff) > MAX_GRANTS)) begin
            single_code = STATUS_REFUSED;
         end else begin
            single = 1'b0;
         end
      end
   end

   // Grant of the current scan entry
   assign grant_ready = slot_free && !map_bit;
   assign grant_last  = (done_ff + CNT_W'(1)) == count_ff;
   assign blk_in_cyl  = scan_idx_ff % IDX_W'(BLOCKS_PER_CYLINDER);

   assign sts.single      = single;
   assign sts.slot_free   = slot_free;
   assign sts.grant_ready = grant_ready;
   assign sts.grant_last  = grant_last;

   // Next values of state and result register
   always_comb begin
      used_map_in  = used_map_ff;
      free_in      = free_ff;
      scan_idx_in  = scan_idx_ff;
      done_in      = done_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      status_in    = status_ff;
      cyl_in       = cyl_ff;
      trk_in       = trk_ff;
      rec_in       = rec_ff;
      last_in      = last_ff;
      fblk_in      = fblk_ff;

      if (cmd.start_scan) begin
         scan_idx_in = '0;
         done_in     = '0;
      end

      if (cmd.emit_single) begin
         rsp_valid_in = 1'b1;
         status_in    = single_code;
         last_in      = 1'b1;
         if (op_ff == OP_RELEASE) begin
            cyl_in = rcyl_ff;
            trk_in = rtrk_ff;
            rec_in = rrec_ff;
            if (rel_hit) begin
               used_map_in[rel_idx] = 1'b0;
               free_in              = free_ff + CNT_W'(1);
            end
         end else begin
            cyl_in = '0;
            trk_in = '0;
            rec_in = '0;
         end
         fblk_in = free_in;
      end

      if (cmd.scan) begin
         if (map_bit) begin
            scan_idx_in = scan_idx_ff + IDX_W'(1);
         end else if (slot_free) begin
            used_map_in[scan_idx_ff] = 1'b1;
            free_in      = free_ff - CNT_W'(1);
            done_in      = done_ff + CNT_W'(1);
            scan_idx_in  = scan_idx_ff + IDX_W'(1);
            rsp_valid_in = 1'b1;
            status_in    = STATUS_GRANTED;
            cyl_in       = CYL_W'(scan_idx_ff / IDX_W'(BLOCKS_PER_CYLINDER));
            trk_in       = TRK_W'(blk_in_cyl / IDX_W'(RECORDS_PER_TRACK));
            rec_in       = REC_W'(blk_in_cyl % IDX_W'(RECORDS_PER_TRACK));
            last_in      = grant_last;
            fblk_in      = free_ff - CNT_W'(1);
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         used_map_ff  <= '0;
         free_ff      <= CNT_W'(TOTAL_BLOCKS);
         rsp_valid_ff <= 1'b0;
      end else begin
         used_map_ff  <= used_map_in;
         free_ff      <= free_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= req_op;
         count_ff <= req_request_count;
         rcyl_ff  <= req_release_cylinder;
         rtrk_ff  <= req_release_track;
         rrec_ff  <= req_release_record;
      end
      scan_idx_ff <= scan_idx_in;
      done_ff     <= done_in;
      status_ff   <= status_in;
      cyl_ff      <= cyl_in;
      trk_ff      <= trk_in;
      rec_ff      <= rec_in;
      last_ff     <= last_in;
      fblk_ff     <= fblk_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_cylinder    = cyl_ff;
   assign rsp_track       = trk_ff;
   assign rsp_record      = rec_ff;
   assign rsp_last        = last_ff;
   assign rsp_free_blocks = fblk_ff;

endmodule

[hdl/bitmap_block_allocator_top.sv]
// Top level of the first-fit bitmap disk block allocator.
//
//  channel  direction  handshake             payload
//  req      in         req_valid/req_stall   op, request_count, release address
//  rsp      out        rsp_valid/rsp_stall   status, address, last, free_blocks
//
// A transaction is captured in the idle state and decided in the next. Release, refusal
// and empty requests then give their one result. An allocation scans the bitmap one
// entry per cycle from block 0, holding on a free entry while the result register
// is stalled, and issues a grant on each free entry until the request is met.
// Synchronous reset marks every block free and sets the free count to 64.
// The result register holds its transaction while rsp_stall is high.
module bitmap_block_allocator_top
   import bba_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic             req_op,
   input  logic [CNT_W-1:0] req_request_count,
   input  logic [CYL_W-1:0] req_release_cylinder,
   input  logic [TRK_W-1:0] req_release_track,
   input  logic [REC_W-1:0] req_release_record,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [STS_W-1:0] rsp_status,
   output logic [CYL_W-1:0] rsp_cylinder,
   output logic [TRK_W-1:0] rsp_track,
   output logic [REC_W-1:0] rsp_record,
   output logic             rsp_last,
   output logic [CNT_W-1:0] rsp_free_blocks
);

   bba_cmd_type cmd;
   bba_sts_type sts;

   bba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   bba_datapath u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .sts                  (sts),
      .req_op               (req_op),
      .req_request_count    (req_request_count),
      .req_release_cylinder (req_release_cylinder),
      .req_release_track    (req_release_track),
      .req_release_record   (req_release_record),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_status           (rsp_status),
      .rsp_cylinder         (rsp_cylinder),
      .rsp_track            (rsp_track),
      .rsp_record           (rsp_record),
      .rsp_last             (rsp_last),
      .rsp_free_blocks      (rsp_free_blocks)
   );

endmodule

[hdl/bba_checker.sv]
// Port-level checks of the allocator and their binding to the top level.
module bba_checker
   import bba_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input logic [STS_W-1:0] rsp_status,
   input logic [CYL_W-1:0] rsp_cylinder,
   input logic [TRK_W-1:0] rsp_track,
   input logic [REC_W-1:0] rsp_record,
   input logic             rsp_last,
   input logic [CNT_W-1:0] rsp_free_blocks
);

   // Only grants may leave a transaction open
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STATUS_GRANTED) |-> rsp_last)
      else $error("non-grant result without last");

   // Refusals and empty requests carry a zero address
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_status == STATUS_REFUSED) || (rsp_status == STATUS_EMPTY))
      |-> (rsp_cylinder == '0) && (rsp_track == '0) && (rsp_record == '0))
      else $error("refusal with non-zero address");

   // Free count never exceeds the disk size
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (int'(rsp_free_blocks) <= TOTAL_BLOCKS))
      else $error("free count above disk size");

   // No new request is taken while an allocation is still issuing grants
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_GRANTED) && !rsp_last |-> req_stall)
      else $error("request taken during allocation");

   // A stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status) && $stable(rsp_free_blocks))
      else $error("stalled result changed");

endmodule

bind bitmap_block_allocator_top bba_checker u_bba_checker (
   .clock           (clock),
   .reset           (reset),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_status      (rsp_status),
   .rsp_cylinder    (rsp_cylinder),
   .rsp_track       (rsp_track),
   .rsp_record      (rsp_record),
   .rsp_last        (rsp_last),
   .rsp_free_blocks (rsp_free_blocks)
);

[tb/sv/tb_bitmap_block_allocator_top.sv]
// Self-checking testbench for the first-fit bitmap disk block allocator.
`timescale 1ns / 1ps

module tb_bitmap_block_allocator_top;
   import bba_pkg::*;

   // Run limits
   localparam int CYCLE_LIMIT  = 2_500_000;
   localparam int DRAIN_CYCLES = 100;
   localparam int IDLE_MAX     = 18;

   // One answer of the allocator
   typedef struct packed {
      logic [STS_W-1:0] status;
      logic [CYL_W-1:0] cylinder;
      logic [TRK_W-1:0] track;
      logic [REC_W-1:0] record;
      logic             last;
      logic [CNT_W-1:0] free_blocks;
   } disk_answer_type;

   // Clock, reset and block ports
   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   logic             req_op = OP_ALLOCATE;
   logic [CNT_W-1:0] req_request_count = '0;
   logic [CYL_W-1:0] req_release_cylinder = '0;
   logic [TRK_W-1:0] req_release_track = '0;
   logic [REC_W-1:0] req_release_record = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   logic [STS_W-1:0] rsp_status;
   logic [CYL_W-1:0] rsp_cylinder;
   logic [TRK_W-1:0] rsp_track;
   logic [REC_W-1:0] rsp_record;
   logic             rsp_last;
   logic [CNT_W-1:0] rsp_free_blocks;

   // Predicted disk state and answers still owed by the block
   logic            disk_used_map [TOTAL_BLOCKS];
   int              disk_free_count;
   disk_answer_type expected_answers [$];

   // Bookkeeping
   int mismatches       = 0;
   int cycle_count      = 0;
   int requests_sent    = 0;
   int answers_checked  = 0;
   int grants_checked   = 0;
   int refusals_checked = 0;
   int req_idle_max     = IDLE_MAX;
   int rsp_idle_max     = IDLE_MAX;

   bitmap_block_allocator_top u_top (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_op               (req_op),
      .req_request_count    (req_request_count),
      .req_release_cylinder (req_release_cylinder),
      .req_release_track    (req_release_track),
      .req_release_record   (req_release_record),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_status           (rsp_status),
      .rsp_cylinder         (rsp_cylinder),
      .rsp_track            (rsp_track),
      .rsp_record           (rsp_record),
      .rsp_last             (rsp_last),
      .rsp_free_blocks      (rsp_free_blocks)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Queue one answer, tagged with the free count as it now stands
   function automatic void owe_answer(input logic [STS_W-1:0] status, input int cyl,
                                      input int trk, input int rec, input logic last);
      disk_answer_type ans;
      ans.status      = status;
      ans.cylinder    = cyl[CYL_W-1:0];
      ans.track       = trk[TRK_W-1:0];
      ans.record      = rec[REC_W-1:0];
      ans.last        = last;
      ans.free_blocks = disk_free_count[CNT_W-1:0];
      expected_answers.insert(expected_answers.size(), ans);
   endfunction

   // First-fit allocator prediction for one accepted transaction
   function automatic void predict_allocator(input logic op, input logic [CNT_W-1:0] want,
                                             input logic [CYL_W-1:0] cyl,
                                             input logic [TRK_W-1:0] trk,
                                             input logic [REC_W-1:0] rec);
      int granted;
      int blk;
      int blk_off;
      granted = 0;
      if (op == OP_ALLOCATE) begin
         if (want == 0)
            owe_answer(STATUS_EMPTY, 0, 0, 0, 1'b1);
         else if (want > disk_free_count || want > MAX_GRANTS)
            owe_answer(STATUS_REFUSED, 0, 0, 0, 1'b1);
         else begin
            for (blk = 0; blk < TOTAL_BLOCKS && granted < want; blk++) begin
               if (!disk_used_map[blk]) begin
                  disk_used_map[blk] = 1'b1;
                  disk_free_count--;
                  granted++;
                  blk_off = blk % BLOCKS_PER_CYLINDER;
                  owe_answer(STATUS_GRANTED, blk / BLOCKS_PER_CYLINDER,
                             blk_off / RECORDS_PER_TRACK, blk_off % RECORDS_PER_TRACK,
                             granted == want);
               end
            end
         end
      end else begin
         blk_off = int'(trk) * RECORDS_PER_TRACK + int'(rec);
         // out-of-range addresses leave the map alone but still get an echo
         if (int'(cyl) < CYLINDERS && blk_off < BLOCKS_PER_CYLINDER) begin
            blk = int'(cyl) * BLOCKS_PER_CYLINDER + blk_off;
            if (disk_used_map[blk]) begin
               disk_used_map[blk] = 1'b0;
               disk_free_count++;
            end
         end
         owe_answer(STATUS_RELEASED, int'(cyl), int'(trk), int'(rec), 1'b1);
      end
   endfunction

   // Present one transaction after a random gap and wait for its acceptance
   task automatic send_transaction(input logic op, input logic [CNT_W-1:0] want,
                                   input logic [CYL_W-1:0] cyl, input logic [TRK_W-1:0] trk,
                                   input logic [REC_W-1:0] rec);
      int gap;
      gap = (req_idle_max > 0) ? $urandom_range(0, req_idle_max) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid            <= 1'b1;
      req_op               <= op;
      req_request_count    <= want;
      req_release_cylinder <= cyl;
      req_release_track    <= trk;
      req_release_record   <= rec;
      // stall is settled by the falling edge; the next rising edge takes it
      do @(negedge clock); while (req_stall !== 1'b0);
      @(posedge clock);
      predict_allocator(op, want, cyl, trk, rec);
      requests_sent++;
   endtask

   // Shorthands: unused fields carry random junk
   task automatic send_allocate(input int want);
      send_transaction(OP_ALLOCATE, want[CNT_W-1:0], CYL_W'($urandom_range(0, 7)),
                       TRK_W'($urandom_range(0, 1)), REC_W'($urandom_range(0, 3)));
   endtask

   task automatic send_release(input int cyl, input int trk, input int rec);
      send_transaction(OP_RELEASE, CNT_W'($urandom_range(0, 127)), cyl[CYL_W-1:0],
                       trk[TRK_W-1:0], rec[REC_W-1:0]);
   endtask

   // Random block currently marked used, or -1
   function automatic int pick_used_block();
      int start;
      int k;
      int idx;
      start = $urandom_range(0, TOTAL_BLOCKS - 1);
      for (k = 0; k < TOTAL_BLOCKS; k++) begin
         idx = (start + k) % TOTAL_BLOCKS;
         if (disk_used_map[idx])
            return idx;
      end
      return -1;
   endfunction

   // One plausible request: mostly releases of owned blocks and sensible allocation sizes
   task automatic send_plausible_request();
      int pick;
      int idx;
      int want;
      int blk_off;
      pick = $urandom_range(0, 99);
      if (disk_free_count == 0 || (disk_free_count < TOTAL_BLOCKS && pick < 45)) begin
         idx = pick_used_block();
         if (idx >= 0 && pick % 10 != 0) begin
            blk_off = idx % BLOCKS_PER_CYLINDER;
            send_release(idx / BLOCKS_PER_CYLINDER, blk_off / RECORDS_PER_TRACK,
                         blk_off % RECORDS_PER_TRACK);
         end else
            send_release($urandom_range(0, 7), $urandom_range(0, 1), $urandom_range(0, 3));
      end else begin
         pick = $urandom_range(0, 99);
         if (pick < 70)
            want = $urandom_range(1, (disk_free_count < 8) ? disk_free_count : 8);
         else if (pick < 85)
            want = $urandom_range(1, disk_free_count);
         else if (pick < 92)
            want = disk_free_count;
         else
            want = $urandom_range(disk_free_count + 1, 127);
         send_allocate(want);
      end
   endtask

   // Receiver: random stall before each answer, then take it
   initial begin
      int hold;
      wait (reset === 1'b0);
      forever begin
         hold = (rsp_idle_max > 0) ? $urandom_range(0, rsp_idle_max) : 0;
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(negedge clock); while (rsp_valid !== 1'b1);
         @(posedge clock);
      end
   end

   function automatic void check_field(input string field, input logic [7:0] expected_value,
                                       input logic [7:0] actual_value);
      if (expected_value !== actual_value) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d",
                  $time, field, expected_value, actual_value);
         mismatches++;
      end
   endfunction

   // Answer checker: anything valid and unstalled at the falling edge is taken next edge
   initial begin
      disk_answer_type want_ans;
      wait (reset === 1'b0);
      forever begin
         @(negedge clock);
         if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            if (expected_answers.size() == 0) begin
               $display("%0t: unexpected answer, expected none, actual status %0d",
                        $time, rsp_status);
               mismatches++;
            end else begin
               want_ans = expected_answers.pop_front();
               check_field("status", 8'(want_ans.status), 8'(rsp_status));
               check_field("cylinder", 8'(want_ans.cylinder), 8'(rsp_cylinder));
               check_field("track", 8'(want_ans.track), 8'(rsp_track));
               check_field("record", 8'(want_ans.record), 8'(rsp_record));
               check_field("last", 8'(want_ans.last), 8'(rsp_last));
               check_field("free_blocks", 8'(want_ans.free_blocks), 8'(rsp_free_blocks));
               answers_checked++;
               if (want_ans.status == STATUS_GRANTED)
                  grants_checked++;
               else if (want_ans.status != STATUS_RELEASED)
                  refusals_checked++;
            end
         end
      end
   end

   // Empty request and oversize requests on a fresh disk
   task automatic test_empty_and_oversize();
      send_allocate(0);
      send_allocate(65);
      send_allocate(127);
      send_allocate(96);
   endtask

   // Releasing blocks that are already free only echoes the address
   task automatic test_release_of_free_block();
      send_release(7, 1, 3);
      send_release(0, 0, 0);
   endtask

   // One request takes the whole disk, then nothing more fits
   task automatic test_fill_whole_disk();
      send_allocate(64);
      send_allocate(1);
      send_allocate(64);
   endtask

   // Scattered releases leave holes that first fit must refill in block order
   task automatic test_first_fit_holes();
      send_release(5, 0, 1);
      send_release(0, 0, 0);
      send_release(7, 1, 3);
      send_release(3, 1, 2);
      send_release(3, 1, 2);
      send_allocate(5);
      send_allocate(4);
      send_release(2, 1, 0);
      send_release(6, 0, 3);
      send_allocate(1);
      send_allocate(2);
      send_allocate(1);
   endtask

   // Mostly sensible traffic with random content
   task automatic test_random_traffic(input int count);
      repeat (count) send_plausible_request();
   endtask

   // Fully random fields, including empty and oversize requests
   task automatic test_random_noise(input int count);
      repeat (count)
         send_transaction(1'($urandom_range(0, 1)), CNT_W'($urandom_range(0, 127)),
                          CYL_W'($urandom_range(0, 7)), TRK_W'($urandom_range(0, 1)),
                          REC_W'($urandom_range(0, 3)));
   endtask

   // Back-to-back transactions with the receiver never stalling
   task automatic test_back_to_back(input int count);
      req_idle_max = 0;
      rsp_idle_max = 0;
      repeat (count) send_plausible_request();
      req_idle_max = IDLE_MAX;
      rsp_idle_max = IDLE_MAX;
   endtask

   // Stimulus sequence
   initial begin
      foreach (disk_used_map[i]) disk_used_map[i] = 1'b0;
      disk_free_count = TOTAL_BLOCKS;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_and_oversize();
      test_release_of_free_block();
      test_fill_whole_disk();
      test_first_fit_holes();
      test_random_traffic(120);
      test_back_to_back(35);
      test_random_noise(45);
      test_random_traffic(60);

      // drain everything still owed
      req_valid <= 1'b0;
      while (expected_answers.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("summary: %0d requests, %0d answers checked (%0d grants, %0d refused or empty)",
               requests_sent, answers_checked, grants_checked, refusals_checked);
      $display("summary: %0d mismatches in %0d cycles", mismatches, cycle_count);
      if (mismatches == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

[bitmap_block_allocator_top.f]
hdl/bba_pkg.sv
hdl/bba_ctrl.sv
hdl/bba_datapath.sv
hdl/bitmap_block_allocator_top.sv
hdl/bba_checker.sv
tb/sv/tb_bitmap_block_allocator_top.sv
